FILE: src/sge_pkg.sv
// Shared types, constants and helper functions of the Sobel edge glow block.
// Used by the interfaces, front, queue, back and top level; depends on nothing.
`default_nettype none
package sge_pkg;

    localparam int PIX_W = 8;
    localparam int VSUM_W = 10;
    localparam int DIFF_W = 9;
    localparam int WGT_W = 9;
    localparam int STR_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MAG_W = 11;
    localparam int PROD_W = MAG_W + STR_W;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [8:0] DIV_K = 9'd255;

    localparam logic [STR_W-1:0] RST_STRENGTH = 16'd256;
    localparam logic [WGT_W-1:0] RST_LUMA_R = 9'd77;
    localparam logic [WGT_W-1:0] RST_LUMA_G = 9'd150;
    localparam logic [WGT_W-1:0] RST_LUMA_B = 9'd29;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRENGTH = 2'd0,
        CFG_LUMA_R   = 2'd1,
        CFG_LUMA_G   = 2'd2,
        CFG_LUMA_B   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] top_red;
        logic [PIX_W-1:0] top_green;
        logic [PIX_W-1:0] top_blue;
        logic [PIX_W-1:0] mid_red;
        logic [PIX_W-1:0] mid_green;
        logic [PIX_W-1:0] mid_blue;
        logic [PIX_W-1:0] bottom_red;
        logic [PIX_W-1:0] bottom_green;
        logic [PIX_W-1:0] bottom_blue;
        logic             first_column;
        logic             last_column;
    } t_col;

    typedef struct packed {
        logic [PIX_W-1:0] glow_red;
        logic [PIX_W-1:0] glow_green;
        logic [PIX_W-1:0] glow_blue;
        logic             row_done;
    } t_pix;

    typedef struct packed {
        logic [STR_W-1:0] strength;
        logic [WGT_W-1:0] wr;
        logic [WGT_W-1:0] wg;
        logic [WGT_W-1:0] wb;
    } t_cfg;

    typedef struct packed {
        logic [VSUM_W-1:0]        vl;
        logic signed [DIFF_W-1:0] dl;
        logic signed [DIFF_W-1:0] dc;
        logic [VSUM_W-1:0]        vr;
        logic signed [DIFF_W-1:0] dr;
        logic [PIX_W-1:0]         luma;
        logic [3*PIX_W-1:0]       colour;
        logic                     done;
    } t_job;

    typedef struct packed {
        logic [1:0] n;
        t_job       j0;
        t_job       j1;
    } t_push;

    function automatic logic [PIX_W-1:0] luma_of(
        input logic [WGT_W-1:0] wr,
        input logic [WGT_W-1:0] wg,
        input logic [WGT_W-1:0] wb,
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b
    );
        logic [18:0] s;
        s = 19'(wr * r) + 19'(wg * g) + 19'(wb * b);
        return (|s[18:16]) ? PIX_MAX : s[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] boost(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] l
    );
        logic signed [10:0] v;
        v = $signed({2'b00, c, 1'b0}) - $signed({3'b000, l});
        if (v[10]) begin
            return '0;
        end else if (|v[9:8]) begin
            return PIX_MAX;
        end
        return v[7:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/sge_if.sv
// Valid/ready channel interfaces: column requests in, glow pixel requests out.
// Payload types come from sge_pkg.
`default_nettype none
interface sge_col_if;
    logic          valid;
    logic          ready;
    sge_pkg::t_col data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sge_pix_if;
    logic          valid;
    logic          ready;
    sge_pkg::t_pix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sge_front.sv
// Front: accepts columns, computes lumas and Sobel column sums, keeps the
// held columns and pushes zero, one or two pixel jobs. Depends on sge_pkg.
`default_nettype none
module sge_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sge_col_if.sink            i_col,
    input  wire sge_pkg::t_cfg i_cfg,
    input  wire logic          i_space2,
    output sge_pkg::t_push     o_push
);

    logic                 r_a_valid;
    sge_pkg::t_col        r_a;
    logic                 r_b_valid;
    logic [7:0]           r_b_t;
    logic [7:0]           r_b_m;
    logic [7:0]           r_b_b;
    logic [23:0]          r_b_col;
    logic                 r_b_first;
    logic                 r_b_last;

    logic                 r_open;
    logic [9:0]           r_v0;
    logic [9:0]           r_v1;
    logic signed [8:0]    r_d0;
    logic signed [8:0]    r_d1;
    logic [7:0]           r_l;
    logic [23:0]          r_c;

    logic                 a_move;
    logic                 b_move;
    logic [9:0]           v;
    logic signed [8:0]    d;
    logic                 start;

    assign b_move = r_b_valid && i_space2;
    assign a_move = r_a_valid && (!r_b_valid || b_move);
    assign i_col.ready = !r_a_valid || a_move;

    assign v = 10'(r_b_t) + {1'b0, r_b_m, 1'b0} + 10'(r_b_b);
    assign d = $signed({1'b0, r_b_b}) - $signed({1'b0, r_b_t});
    assign start = r_b_first || !r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_open <= 1'b0;
        end else begin
            if (i_col.ready) begin
                r_a_valid <= i_col.valid;
            end
            if (!r_b_valid || b_move) begin
                r_b_valid <= a_move;
            end
            if (b_move) begin
                r_open <= !r_b_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_col.valid && i_col.ready) begin
            r_a <= i_col.data;
        end
        if (a_move) begin
            r_b_t <= sge_pkg::luma_of(i_cfg.wr, i_cfg.wg, i_cfg.wb,
                                      r_a.top_red, r_a.top_green, r_a.top_blue);
            r_b_m <= sge_pkg::luma_of(i_cfg.wr, i_cfg.wg, i_cfg.wb,
                                      r_a.mid_red, r_a.mid_green, r_a.mid_blue);
            r_b_b <= sge_pkg::luma_of(i_cfg.wr, i_cfg.wg, i_cfg.wb,
                                      r_a.bottom_red, r_a.bottom_green,
                                      r_a.bottom_blue);
            r_b_col <= {r_a.mid_red, r_a.mid_green, r_a.mid_blue};
            r_b_first <= r_a.first_column;
            r_b_last <= r_a.last_column;
        end
        if (b_move && !r_b_last) begin
            if (start) begin
                r_v0 <= v;
                r_d0 <= d;
            end else begin
                r_v0 <= r_v1;
                r_d0 <= r_d1;
            end
            r_v1 <= v;
            r_d1 <= d;
            r_l <= r_b_m;
            r_c <= r_b_col;
        end
    end

    always_comb begin
        o_push = '0;
        o_push.j1.vl = r_v1;
        o_push.j1.dl = r_d1;
        o_push.j1.dc = d;
        o_push.j1.vr = v;
        o_push.j1.dr = d;
        o_push.j1.luma = r_b_m;
        o_push.j1.colour = r_b_col;
        o_push.j1.done = 1'b1;
        if (start) begin
            o_push.j0.vl = v;
            o_push.j0.dl = d;
            o_push.j0.dc = d;
            o_push.j0.luma = r_b_m;
            o_push.j0.colour = r_b_col;
            o_push.j0.done = 1'b1;
        end else begin
            o_push.j0.vl = r_v0;
            o_push.j0.dl = r_d0;
            o_push.j0.dc = r_d1;
            o_push.j0.luma = r_l;
            o_push.j0.colour = r_c;
            o_push.j0.done = 1'b0;
        end
        o_push.j0.vr = v;
        o_push.j0.dr = d;
        if (b_move) begin
            priority if (start) begin
                o_push.n = r_b_last ? 2'd1 : 2'd0;
            end else begin
                o_push.n = r_b_last ? 2'd2 : 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n != 2'd0 && o_push.j0.done) |=> !r_open)
        else $error("span still open after final pixel pushed");
`endif

endmodule
`default_nettype wire

FILE: src/sge_queue.sv
// Job queue between front and back: up to two pushes and one pop per cycle.
// Depends on sge_pkg for the job type and depth.
`default_nettype none
module sge_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sge_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_space2,
    output logic                o_valid,
    output sge_pkg::t_job       o_job
);

    sge_pkg::t_job              r_mem [sge_pkg::QDEPTH];
    logic [sge_pkg::QAW-1:0]    r_wr_ptr;
    logic [sge_pkg::QAW-1:0]    r_rd_ptr;
    logic [sge_pkg::QAW:0]      r_count;
    logic [sge_pkg::QAW-1:0]    wr_ptr1;
    logic                       pop;

    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign o_valid = r_count != '0;
    assign o_space2 = r_count <= (sge_pkg::QAW + 1)'(sge_pkg::QDEPTH - 2);
    assign o_job = r_mem[r_rd_ptr];
    assign pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + sge_pkg::QAW'(i_push.n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (sge_pkg::QAW + 1)'(i_push.n)
                       - (sge_pkg::QAW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.j0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.j1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> o_space2)
        else $error("push into queue without room");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (sge_pkg::QAW + 1)'(sge_pkg::QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: src/sge_back.sv
// Back: three-stage pipeline from job to glow pixel (gain multiply, colour
// boost and multiply, divide by 255 into the output register). Uses sge_pkg.
`default_nettype none
module sge_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire sge_pkg::t_job              i_job,
    input  wire logic [sge_pkg::STR_W-1:0]  i_strength,
    output logic                            o_pop,
    sge_pix_if.source                       o_pix
);

    logic                          r_s1_v;
    logic                          r_s2_v;
    logic                          r_s3_v;
    logic [sge_pkg::PROD_W-1:0]    r_s1_prod;
    logic [7:0]                    r_s1_l;
    logic [23:0]                   r_s1_c;
    logic                          r_s1_done;
    logic [15:0]                   r_s2_r;
    logic [15:0]                   r_s2_g;
    logic [15:0]                   r_s2_b;
    logic                          r_s2_done;
    sge_pkg::t_pix                 r_s3;

    logic                          advance;
    logic signed [10:0]            gx;
    logic signed [10:0]            gy;
    logic [10:0]                   ax;
    logic [10:0]                   ay;
    logic [sge_pkg::MAG_W-1:0]     mag_sum;
    logic [18:0]                   scaled;
    logic [7:0]                    mag;

    assign advance = !r_s3_v || o_pix.ready;
    assign o_pop = advance && i_q_valid;
    assign o_pix.valid = r_s3_v;
    assign o_pix.data = r_s3;

    assign gx = $signed({1'b0, i_job.vr}) - $signed({1'b0, i_job.vl});
    assign gy = 11'(i_job.dl) + 11'(i_job.dc <<< 1) + 11'(i_job.dr);
    assign ax = gx[10] ? 11'(-gx) : 11'(gx);
    assign ay = gy[10] ? 11'(-gy) : 11'(gy);
    assign mag_sum = ax + ay;

    assign scaled = r_s1_prod[sge_pkg::PROD_W-1:8];
    assign mag = (|scaled[18:8]) ? sge_pkg::PIX_MAX : scaled[7:0];

    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [8:0] rem;
        logic [8:0] q;
        rem = {1'b0, p[7:0]} + {1'b0, p[15:8]};
        q = {1'b0, p[15:8]} + 9'(rem >= sge_pkg::DIV_K);
        return q[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (advance) begin
            r_s1_v <= i_q_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_prod <= mag_sum * i_strength;
            r_s1_l <= i_job.luma;
            r_s1_c <= i_job.colour;
            r_s1_done <= i_job.done;
            r_s2_r <= sge_pkg::boost(r_s1_c[23:16], r_s1_l) * mag;
            r_s2_g <= sge_pkg::boost(r_s1_c[15:8], r_s1_l) * mag;
            r_s2_b <= sge_pkg::boost(r_s1_c[7:0], r_s1_l) * mag;
            r_s2_done <= r_s1_done;
            r_s3.glow_red <= div255(r_s2_r);
            r_s3.glow_green <= div255(r_s2_g);
            r_s3.glow_blue <= div255(r_s2_b);
            r_s3.row_done <= r_s2_done;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_s1_v) && $stable(r_s2_v) && r_s3_v))
        else $error("back pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire

FILE: src/sobel_glow_edge_pixel_top.sv
// Top level of the Sobel edge glow block: configuration registers, front,
// job queue and back. Depends on sge_pkg, sge_if, sge_front, sge_queue, sge_back.
//
//   channel   dir  handshake      payload
//   i_col     in   valid/ready    one column: top, mid, bottom RGB, span marks
//   o_pix     out  valid/ready    one glow pixel RGB and row_done
//   i_cfg_*   in   write enable   register index 0..3, 16-bit data
//
// One column is taken per cycle while the queue has room; a last column yields
// two pixels, so a span of N columns gives N pixels. A pixel passes the front's
// column and luma registers, the queue and the back's gain, boost and divide
// stages. Synchronous reset restores default gain and weights. A stalled output
// holds the back pipeline; the front stops when the queue lacks room for two jobs.
`default_nettype none
module sobel_glow_edge_pixel_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sge_col_if.sink                            i_col,
    sge_pix_if.source                          o_pix,
    input  wire logic                          i_cfg_we,
    input  wire logic [sge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sge_pkg::CFG_W-1:0]     i_cfg_data
);

    sge_pkg::t_cfg  r_cfg;
    sge_pkg::t_push push;
    logic           space2;
    logic           q_valid;
    sge_pkg::t_job  q_job;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strength <= sge_pkg::RST_STRENGTH;
            r_cfg.wr <= sge_pkg::RST_LUMA_R;
            r_cfg.wg <= sge_pkg::RST_LUMA_G;
            r_cfg.wb <= sge_pkg::RST_LUMA_B;
        end else if (i_cfg_we) begin
            unique case (sge_pkg::t_cfg_idx'(i_cfg_idx))
                sge_pkg::CFG_STRENGTH: r_cfg.strength <= i_cfg_data;
                sge_pkg::CFG_LUMA_R: r_cfg.wr <= i_cfg_data[sge_pkg::WGT_W-1:0];
                sge_pkg::CFG_LUMA_G: r_cfg.wg <= i_cfg_data[sge_pkg::WGT_W-1:0];
                sge_pkg::CFG_LUMA_B: r_cfg.wb <= i_cfg_data[sge_pkg::WGT_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    sge_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_col    (i_col),
        .i_cfg    (r_cfg),
        .i_space2 (space2),
        .o_push   (push)
    );

    sge_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_space2 (space2),
        .o_valid  (q_valid),
        .o_job    (q_job)
    );

    sge_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (q_job),
        .i_strength (r_cfg.strength),
        .o_pop      (pop),
        .o_pix      (o_pix)
    );

endmodule
`default_nettype wire
